// ===== design/nec_ir_symbol_generator_macros.svh =====
// Assertion macros used by the symbol generator design file.
`ifndef NEC_IR_SYMBOL_GENERATOR_MACROS_SVH
`define NEC_IR_SYMBOL_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define NIRSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NIRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NIRSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NIRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/nirsg_pkg.sv =====
package nirsg_pkg;

  localparam int MAX_REPEATS = 5;
  localparam int REP_W       = $clog2(MAX_REPEATS + 1);

  localparam int MARK_W  = 14;
  localparam int SPACE_W = 13;

  localparam logic [MARK_W-1:0]  LEAD_MARK  = 14'd9000;
  localparam logic [SPACE_W-1:0] LEAD_SPACE = 13'd4500;
  localparam logic [MARK_W-1:0]  BIT_MARK   = 14'd560;
  localparam logic [SPACE_W-1:0] ZERO_SPACE = 13'd560;
  localparam logic [SPACE_W-1:0] ONE_SPACE  = 13'd1690;
  localparam logic [SPACE_W-1:0] RPT_SPACE  = 13'd2250;

  localparam logic [16:0] CARRIER_MIN = 17'd30000;
  localparam logic [16:0] CARRIER_MAX = 17'd60000;
  localparam logic [15:0] WAIT_MAX    = 16'd1000;
  localparam logic [7:0]  REPS_MAX    = 8'(MAX_REPEATS);

  typedef struct packed {
    logic        protocol_is_nec;
    logic [16:0] carrier_freq_hz;
    logic [15:0] wait_limit_ms;
    logic [7:0]  device_address;
    logic [7:0]  command_byte;
    logic [7:0]  repeat_frames;
  } req_t;

  typedef struct packed {
    logic [MARK_W-1:0]  mark_us;
    logic [SPACE_W-1:0] space_us;
    logic               in_repeat;
    logic               rejected;
    logic               last_symbol;
  } sym_t;

  // Microprogram addresses.
  localparam logic [2:0] STEP_LEADER   = 3'd0;
  localparam logic [2:0] STEP_DATA     = 3'd1;
  localparam logic [2:0] STEP_STOP     = 3'd2;
  localparam logic [2:0] STEP_RPT_LEAD = 3'd3;
  localparam logic [2:0] STEP_RPT_STOP = 3'd4;
  localparam logic [2:0] STEP_REJECT   = 3'd5;

  // Mark selects.
  localparam logic [1:0] MK_NONE = 2'd0;
  localparam logic [1:0] MK_LEAD = 2'd1;
  localparam logic [1:0] MK_BIT  = 2'd2;

  // Space selects.
  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_LEAD = 2'd1;
  localparam logic [1:0] SP_RPT  = 2'd2;
  localparam logic [1:0] SP_DATA = 2'd3;

  // Sequencing conditions.
  localparam logic [2:0] COND_NEXT      = 3'd0;
  localparam logic [2:0] COND_BITS      = 3'd1;
  localparam logic [2:0] COND_END_NOREP = 3'd2;
  localparam logic [2:0] COND_LOOP_REP  = 3'd3;
  localparam logic [2:0] COND_END       = 3'd4;

  typedef struct packed {
    logic [1:0] mark_sel;
    logic [1:0] space_sel;
    logic       rpt;
    logic       rej;
    logic [2:0] cond;
    logic [2:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [2:0] step);
    ucode_t uw;
    uw = '{MK_NONE, SP_NONE, 1'b0, 1'b0, COND_END, STEP_LEADER};
    unique case (step)
      STEP_LEADER:   uw = '{MK_LEAD, SP_LEAD, 1'b0, 1'b0, COND_NEXT,      STEP_DATA};
      STEP_DATA:     uw = '{MK_BIT,  SP_DATA, 1'b0, 1'b0, COND_BITS,      STEP_DATA};
      STEP_STOP:     uw = '{MK_BIT,  SP_NONE, 1'b0, 1'b0, COND_END_NOREP, STEP_RPT_LEAD};
      STEP_RPT_LEAD: uw = '{MK_LEAD, SP_RPT,  1'b1, 1'b0, COND_NEXT,      STEP_RPT_STOP};
      STEP_RPT_STOP: uw = '{MK_BIT,  SP_NONE, 1'b1, 1'b0, COND_LOOP_REP,  STEP_RPT_LEAD};
      STEP_REJECT:   uw = '{MK_NONE, SP_NONE, 1'b0, 1'b1, COND_END,       STEP_LEADER};
      default:       uw = '{MK_NONE, SP_NONE, 1'b0, 1'b1, COND_END,       STEP_LEADER};
    endcase
    return uw;
  endfunction

endpackage

// ===== design/nirsg_ifs.sv =====
interface nirsg_req_if;
  logic              valid;
  logic              ready;
  nirsg_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nirsg_sym_if;
  logic              valid;
  logic              ready;
  nirsg_pkg::sym_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nec_ir_symbol_generator.sv =====
// NEC infrared symbol generator. Each request is checked first; a bad request yields one
// rejected item, a good one yields the leader, 32 data bits (address, inverted address,
// command, inverted command, LSB first), a stop symbol and two symbols per repeat frame,
// all as mark/space durations in microseconds, the final one flagged last_symbol. A small
// microprogram with a step counter emits one symbol per clock into the output register
// while the output side keeps up, so a good request yields 34 + 2 * repeat_frames symbols
// (34 to 44) and a rejected one yields one. The next request is taken as soon as
// the last symbol has entered the output register.
`include "nec_ir_symbol_generator_macros.svh"

module nec_ir_symbol_generator (
  input  logic               clk,
  input  logic               rst_n,
  nirsg_req_if.sink          in_req,
  nirsg_sym_if.source        out_sym
);

  logic                          busy_r, busy_nxt;
  logic [2:0]                    pc_r, pc_nxt;
  logic [4:0]                    bit_cnt_r, bit_cnt_nxt;
  logic [31:0]                   word_r, word_nxt;
  logic [nirsg_pkg::REP_W-1:0]   rep_r, rep_nxt;
  logic                          out_valid_r, out_valid_nxt;
  nirsg_pkg::sym_t               out_data_r, out_data_nxt;

  nirsg_pkg::ucode_t             uw;
  logic                          in_fire;
  logic                          step_go;
  logic                          req_ok;
  logic                          last;
  nirsg_pkg::req_t               req;

  assign req     = in_req.data;
  assign in_fire = in_req.valid && in_req.ready;
  assign step_go = busy_r && (!out_valid_r || out_sym.ready);
  assign uw      = nirsg_pkg::ucode_rom(pc_r);

  assign req_ok = req.protocol_is_nec
               && (req.carrier_freq_hz >= nirsg_pkg::CARRIER_MIN)
               && (req.carrier_freq_hz <= nirsg_pkg::CARRIER_MAX)
               && (req.repeat_frames <= nirsg_pkg::REPS_MAX)
               && (req.wait_limit_ms != 16'd0)
               && (req.wait_limit_ms <= nirsg_pkg::WAIT_MAX);

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    bit_cnt_nxt   = bit_cnt_r;
    word_nxt      = word_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    last          = 1'b0;

    if (in_fire) begin
      busy_nxt    = 1'b1;
      pc_nxt      = req_ok ? nirsg_pkg::STEP_LEADER : nirsg_pkg::STEP_REJECT;
      bit_cnt_nxt = '0;
      word_nxt    = {~req.command_byte, req.command_byte,
                     ~req.device_address, req.device_address};
      rep_nxt     = req.repeat_frames[nirsg_pkg::REP_W-1:0];
    end else if (step_go) begin
      unique case (uw.cond)
        nirsg_pkg::COND_NEXT: begin
          pc_nxt = pc_r + 3'd1;
        end
        nirsg_pkg::COND_BITS: begin
          bit_cnt_nxt = bit_cnt_r + 5'd1;
          word_nxt    = {1'b0, word_r[31:1]};
          if (bit_cnt_r == 5'd31) begin
            pc_nxt = pc_r + 3'd1;
          end
        end
        nirsg_pkg::COND_END_NOREP: begin
          if (rep_r == '0) begin
            last     = 1'b1;
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = uw.target;
          end
        end
        nirsg_pkg::COND_LOOP_REP: begin
          rep_nxt = rep_r - nirsg_pkg::REP_W'(1);
          if (rep_r == nirsg_pkg::REP_W'(1)) begin
            last     = 1'b1;
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = uw.target;
          end
        end
        nirsg_pkg::COND_END: begin
          last     = 1'b1;
          busy_nxt = 1'b0;
        end
        default: begin
          last     = 1'b1;
          busy_nxt = 1'b0;
        end
      endcase
    end

    if (step_go) begin
      out_valid_nxt = 1'b1;
      unique case (uw.mark_sel)
        nirsg_pkg::MK_LEAD: out_data_nxt.mark_us = nirsg_pkg::LEAD_MARK;
        nirsg_pkg::MK_BIT:  out_data_nxt.mark_us = nirsg_pkg::BIT_MARK;
        default:            out_data_nxt.mark_us = '0;
      endcase
      unique case (uw.space_sel)
        nirsg_pkg::SP_LEAD: out_data_nxt.space_us = nirsg_pkg::LEAD_SPACE;
        nirsg_pkg::SP_RPT:  out_data_nxt.space_us = nirsg_pkg::RPT_SPACE;
        nirsg_pkg::SP_DATA: out_data_nxt.space_us =
                              word_r[0] ? nirsg_pkg::ONE_SPACE : nirsg_pkg::ZERO_SPACE;
        default:            out_data_nxt.space_us = '0;
      endcase
      out_data_nxt.in_repeat   = uw.rpt;
      out_data_nxt.rejected    = uw.rej;
      out_data_nxt.last_symbol = last;
    end else if (out_sym.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= nirsg_pkg::STEP_LEADER;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    rep_r      <= rep_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_req.ready  = !busy_r;
  assign out_sym.valid = out_valid_r;
  assign out_sym.data  = out_data_r;

  `NIRSG_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, busy_r)
  `NIRSG_ASSERT_IMPLY(a_bits_in_data, clk, rst_n, bit_cnt_r != 5'd0,
                      pc_r == nirsg_pkg::STEP_DATA)
  `NIRSG_ASSERT_IMPLY(a_reject_last, clk, rst_n, out_valid_r && out_data_r.rejected,
                      out_data_r.last_symbol && (out_data_r.mark_us == '0))
  `NIRSG_ASSERT_IMPLY(a_repeat_marks, clk, rst_n, out_valid_r && out_data_r.in_repeat,
                      !out_data_r.rejected && (out_data_r.mark_us == nirsg_pkg::LEAD_MARK
                      || out_data_r.mark_us == nirsg_pkg::BIT_MARK))

endmodule
